### rtl/core/tbr_pkg.sv
// Shared constants and register codes for the triangle bounding-box rasterizer.
package tbr_pkg;

  localparam int COORD_BITS_DEFAULT = 12;
  localparam int CFG_INDEX_BITS     = 3;
  localparam int NUM_VERTEX_REGS    = 6;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_A_X = 3'd0,
    REG_A_Y = 3'd1,
    REG_B_X = 3'd2,
    REG_B_Y = 3'd3,
    REG_C_X = 3'd4,
    REG_C_Y = 3'd5
  } cfg_reg_t;

endpackage

### rtl/core/tbr_front.sv
// Front end: vertex registers, bounding box and scan position sequencing.
module tbr_front #(
  parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic [tbr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]                 cfg_data,
  input  logic                                  accept,
  input  logic                                  restart,
  output logic signed [COORD_BITS-1:0]          vtx [tbr_pkg::NUM_VERTEX_REGS],
  output logic signed [COORD_BITS-1:0]          pos_x,
  output logic signed [COORD_BITS-1:0]          pos_y,
  output logic                                  pos_last
);

  logic signed [COORD_BITS-1:0] scan_x;
  logic signed [COORD_BITS-1:0] scan_y;
  logic                         rewind;
  logic signed [COORD_BITS-1:0] x0, x1, y0, y1;
  logic signed [COORD_BITS-1:0] scan_x_next, scan_y_next;
  logic                         use_min;
  logic                         cfg_hit;

  function automatic logic signed [COORD_BITS-1:0] min3(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b,
    input logic signed [COORD_BITS-1:0] c
  );
    logic signed [COORD_BITS-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] max3(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b,
    input logic signed [COORD_BITS-1:0] c
  );
    logic signed [COORD_BITS-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  always_comb begin
    x0 = min3(vtx[tbr_pkg::REG_A_X], vtx[tbr_pkg::REG_B_X], vtx[tbr_pkg::REG_C_X]);
    x1 = max3(vtx[tbr_pkg::REG_A_X], vtx[tbr_pkg::REG_B_X], vtx[tbr_pkg::REG_C_X]);
    y0 = min3(vtx[tbr_pkg::REG_A_Y], vtx[tbr_pkg::REG_B_Y], vtx[tbr_pkg::REG_C_Y]);
    y1 = max3(vtx[tbr_pkg::REG_A_Y], vtx[tbr_pkg::REG_B_Y], vtx[tbr_pkg::REG_C_Y]);
  end

  always_comb begin
    use_min  = restart | rewind;
    pos_x    = use_min ? x0 : scan_x;
    pos_y    = use_min ? y0 : scan_y;
    pos_last = (pos_x == x1) && (pos_y == y1);
    if (pos_last) begin
      scan_x_next = x0;
      scan_y_next = y0;
    end else if (pos_y >= y1) begin
      scan_x_next = pos_x + COORD_BITS'(1);
      scan_y_next = y0;
    end else begin
      scan_x_next = pos_x;
      scan_y_next = pos_y + COORD_BITS'(1);
    end
  end

  always_comb begin
    case (tbr_pkg::cfg_reg_t'(cfg_index))
      tbr_pkg::REG_A_X, tbr_pkg::REG_A_Y,
      tbr_pkg::REG_B_X, tbr_pkg::REG_B_Y,
      tbr_pkg::REG_C_X, tbr_pkg::REG_C_Y: cfg_hit = cfg_valid;
      default:                            cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rewind <= 1'b1;
      for (int i = 0; i < tbr_pkg::NUM_VERTEX_REGS; i++) begin
        vtx[i] <= '0;
      end
    end else if (cfg_hit) begin
      vtx[cfg_index[tbr_pkg::CFG_INDEX_BITS-1:0]] <= cfg_data;
      rewind <= 1'b1;
    end else if (accept) begin
      rewind <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan_x <= scan_x_next;
      scan_y <= scan_y_next;
    end
  end

endmodule

### rtl/core/tbr_fifo.sv
// Two-entry queue between the scan front end and the edge evaluation back end.
module tbr_fifo #(
  parameter int DW = 2 * tbr_pkg::COORD_BITS_DEFAULT + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output logic [DW-1:0] pop_data
);

  logic [DW-1:0] mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/core/tbr_back.sv
// Back end: two-stage edge function pipeline with registered result word.
module tbr_back #(
  parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [COORD_BITS-1:0] vtx [tbr_pkg::NUM_VERTEX_REGS],
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic                         inside_res,
  output logic                         last_pixel
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int EW = PW + 1;

  logic                         s1_valid;
  logic signed [COORD_BITS-1:0] s1_x, s1_y;
  logic                         s1_last;
  logic signed [PW-1:0]         s1_prod [6];
  logic signed [PW-1:0]         prod [6];
  logic signed [EW-1:0]         e [3];
  logic [2:0]                   neg, pos;
  logic                         s2_ready, s1_ready;

  function automatic logic signed [DW-1:0] dif(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    return DW'(a) - DW'(b);
  endfunction

  function automatic logic signed [PW-1:0] mul(
    input logic signed [DW-1:0] a,
    input logic signed [DW-1:0] b
  );
    return PW'(a) * PW'(b);
  endfunction

  always_comb begin
    prod[0] = mul(dif(vtx[tbr_pkg::REG_B_X], vtx[tbr_pkg::REG_A_X]),
                  dif(in_y, vtx[tbr_pkg::REG_A_Y]));
    prod[1] = mul(dif(vtx[tbr_pkg::REG_B_Y], vtx[tbr_pkg::REG_A_Y]),
                  dif(in_x, vtx[tbr_pkg::REG_A_X]));
    prod[2] = mul(dif(vtx[tbr_pkg::REG_C_X], vtx[tbr_pkg::REG_B_X]),
                  dif(in_y, vtx[tbr_pkg::REG_B_Y]));
    prod[3] = mul(dif(vtx[tbr_pkg::REG_C_Y], vtx[tbr_pkg::REG_B_Y]),
                  dif(in_x, vtx[tbr_pkg::REG_B_X]));
    prod[4] = mul(dif(vtx[tbr_pkg::REG_A_X], vtx[tbr_pkg::REG_C_X]),
                  dif(in_y, vtx[tbr_pkg::REG_C_Y]));
    prod[5] = mul(dif(vtx[tbr_pkg::REG_A_Y], vtx[tbr_pkg::REG_C_Y]),
                  dif(in_x, vtx[tbr_pkg::REG_C_X]));
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e[i]   = EW'(s1_prod[2*i]) - EW'(s1_prod[2*i+1]);
      neg[i] = e[i][EW-1];
      pos[i] = !e[i][EW-1] && (e[i] != '0);
    end
  end

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_x    <= in_x;
      s1_y    <= in_y;
      s1_last <= in_last;
      s1_prod <= prod;
    end
    if (s2_ready && s1_valid) begin
      pixel_x    <= s1_x;
      pixel_y    <= s1_y;
      last_pixel <= s1_last;
      inside_res <= (neg == 3'b000) || (pos == 3'b000);
    end
  end

endmodule

### rtl/core/triangle_bbox_edge_rasterizer.sv
// Top level of the triangle bounding-box edge-function rasterizer.
// Each accepted input word yields one result word: the next pixel of the
// triangle's bounding box (x outer, y inner, wrapping after the last pixel),
// its inside flag and its last flag. One word is accepted every clock while
// the queue is not full; a result word passes through the queue entry, the
// edge product stage and the result register, and the result register
// holds it until it is taken. A two-entry queue sits between the scan front
// end and the edge pipeline. Vertex writes always complete at once and move
// the scan back to the box's minimum corner.
module triangle_bbox_edge_rasterizer #(
  parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tbr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]              cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               restart,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [COORD_BITS-1:0]       pixel_x,
  output logic signed [COORD_BITS-1:0]       pixel_y,
  output logic                               inside_res,
  output logic                               last_pixel
);

  localparam int QW = 2 * COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] vtx [tbr_pkg::NUM_VERTEX_REGS];
  logic signed [COORD_BITS-1:0] pos_x, pos_y, q_x, q_y;
  logic                         pos_last, q_last;
  logic                         q_full, q_valid, q_pop, back_ready;
  logic                         accept;
  logic [QW-1:0]                q_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && !q_full;
  assign q_pop     = q_valid && back_ready;
  assign q_x       = q_data[QW-1 -: COORD_BITS];
  assign q_y       = q_data[COORD_BITS:1];
  assign q_last    = q_data[0];

  tbr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .restart  (restart),
    .vtx      (vtx),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_last (pos_last)
  );

  tbr_fifo #(.DW(QW)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data({pos_x, pos_y, pos_last}),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .pop_data (q_data)
  );

  tbr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .vtx       (vtx),
    .in_valid  (q_valid),
    .in_ready  (back_ready),
    .in_x      (q_x),
    .in_y      (q_y),
    .in_last   (q_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .inside_res(inside_res),
    .last_pixel(last_pixel)
  );

endmodule

### rtl/core/tbr_checker.sv
// Port-level checks for the rasterizer, bound to the top level.
module tbr_checker #(
  parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEFAULT
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] pixel_x,
  input logic [COORD_BITS-1:0] pixel_y,
  input logic                  inside_res,
  input logic                  last_pixel
);

  a_reset_empty: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("queue or output not empty after reset");

  a_cfg_always: assert property (@(posedge clk) disable iff (rst) cfg_valid |-> cfg_ready)
    else $error("configuration word stalled");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pixel_x) && $stable(pixel_y)
                              && $stable(inside_res) && $stable(last_pixel))
    else $error("result word changed while stalled");

endmodule

bind triangle_bbox_edge_rasterizer tbr_checker #(.COORD_BITS(COORD_BITS)) u_tbr_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pixel_x   (pixel_x),
  .pixel_y   (pixel_y),
  .inside_res(inside_res),
  .last_pixel(last_pixel)
);

### bench/tb_triangle_bbox_edge_rasterizer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the triangle bounding-box edge rasterizer.
module tb_triangle_bbox_edge_rasterizer;
  import tbr_pkg::*;

  localparam int CW = COORD_BITS_DEFAULT;
  localparam int IW = CFG_INDEX_BITS;
  localparam int CMIN = -(1 << (CW - 1));
  localparam int CMAX = (1 << (CW - 1)) - 1;
  localparam logic [IW-1:0] REG_NONE_LO = 3'd6;
  localparam logic [IW-1:0] REG_NONE_HI = 3'd7;
  localparam int ITEM_TARGET = 1700;
  localparam int HOLD_CYCLES = 80;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 covered;
    logic                 last;
  } pixel_t;

  typedef enum {RUN_FROM_CORNER, RUN_SPARSE, RUN_NOISY} run_style_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [IW-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          restart = 1'b0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic signed [CW-1:0] pixel_x;
  logic signed [CW-1:0] pixel_y;
  logic          inside_res;
  logic          last_pixel;

  bit     pending_restart[$];
  pixel_t pixel_expect[$];
  logic   in_acc = 1'b0;
  int     send_idle = 0;
  int     recv_idle = 0;
  int     hold_req = 0;
  int     hold_seen = 0;
  int     hold_left = 0;
  int     cycles = 0;
  int     failures = 0;
  int     queued = 0;
  int     n_words = 0;
  int     n_last = 0;
  int     n_inside = 0;

  int vert_x[3];
  int vert_y[3];
  int scan_x;
  int scan_y;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  triangle_bbox_edge_rasterizer #(
    .COORD_BITS(CW)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .inside_res(inside_res),
    .last_pixel(last_pixel)
  );

  function automatic int lo3(int a, int b, int c);
    int m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic int hi3(int a, int b, int c);
    int m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic longint cross_term(int p, int q, int px, int py);
    return longint'(vert_x[q] - vert_x[p]) * longint'(py - vert_y[p]) -
           longint'(vert_y[q] - vert_y[p]) * longint'(px - vert_x[p]);
  endfunction

  function automatic bit covers(int px, int py);
    longint e1, e2, e3;
    e1 = cross_term(0, 1, px, py);
    e2 = cross_term(1, 2, px, py);
    e3 = cross_term(2, 0, px, py);
    return (e1 >= 0 && e2 >= 0 && e3 >= 0) || (e1 <= 0 && e2 <= 0 && e3 <= 0);
  endfunction

  function automatic pixel_t scan_pixel(bit from_corner);
    pixel_t p;
    int x0, x1, y0, y1, px, py;
    x0 = lo3(vert_x[0], vert_x[1], vert_x[2]);
    x1 = hi3(vert_x[0], vert_x[1], vert_x[2]);
    y0 = lo3(vert_y[0], vert_y[1], vert_y[2]);
    y1 = hi3(vert_y[0], vert_y[1], vert_y[2]);
    px = from_corner ? x0 : scan_x;
    py = from_corner ? y0 : scan_y;
    p.x = px[CW-1:0];
    p.y = py[CW-1:0];
    p.covered = covers(px, py);
    p.last = (px == x1) && (py == y1);
    if (p.last) begin
      scan_x = x0;
      scan_y = y0;
    end else if (py >= y1) begin
      scan_x = px + 1;
      scan_y = y0;
    end else begin
      scan_y = py + 1;
      scan_x = px;
    end
    return p;
  endfunction

  // predict on accepted input words and vertex writes, check result words
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      vert_x = '{0, 0, 0};
      vert_y = '{0, 0, 0};
      scan_x = 0;
      scan_y = 0;
      in_acc <= 1'b0;
    end else begin
      in_acc <= in_valid && in_ready;
      if (cfg_valid && cfg_ready && cfg_index < NUM_VERTEX_REGS) begin
        case (cfg_reg_t'(cfg_index))
          REG_A_X: vert_x[0] = $signed(cfg_data);
          REG_A_Y: vert_y[0] = $signed(cfg_data);
          REG_B_X: vert_x[1] = $signed(cfg_data);
          REG_B_Y: vert_y[1] = $signed(cfg_data);
          REG_C_X: vert_x[2] = $signed(cfg_data);
          REG_C_Y: vert_y[2] = $signed(cfg_data);
          default: ;
        endcase
        scan_x = lo3(vert_x[0], vert_x[1], vert_x[2]);
        scan_y = lo3(vert_y[0], vert_y[1], vert_y[2]);
      end
      if (out_valid && out_ready) begin
        if (pixel_expect.size() == 0) begin
          $error("unexpected result word: pixel_x %0d pixel_y %0d", pixel_x, pixel_y);
          failures++;
        end else begin
          want = pixel_expect.pop_front();
          if (pixel_x !== want.x) begin
            $error("pixel_x: expected %0d, got %0d", want.x, pixel_x);
            failures++;
          end
          if (pixel_y !== want.y) begin
            $error("pixel_y: expected %0d, got %0d", want.y, pixel_y);
            failures++;
          end
          if (inside_res !== want.covered) begin
            $error("inside_res: expected %0b, got %0b", want.covered, inside_res);
            failures++;
          end
          if (last_pixel !== want.last) begin
            $error("last_pixel: expected %0b, got %0b", want.last, last_pixel);
            failures++;
          end
          n_last += want.last;
          n_inside += want.covered;
        end
      end
      if (in_valid && in_ready) begin
        pixel_expect.push_back(scan_pixel(restart));
        n_words++;
      end
    end
  end

  // input word driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (pending_restart.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        restart <= pending_restart.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and long hold-offs
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [IW-1:0] idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CW-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic settle_cfg();
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_triangle(input int ax, input int ay, input int bx, input int by,
                               input int cx, input int cy);
    write_reg(REG_A_X, ax);
    write_reg(REG_A_Y, ay);
    write_reg(REG_B_X, bx);
    write_reg(REG_B_Y, by);
    write_reg(REG_C_X, cx);
    write_reg(REG_C_Y, cy);
  endtask

  task automatic push_word(input bit r);
    pending_restart.push_back(r);
    queued++;
  endtask

  task automatic queue_words(input int count, input run_style_t style);
    bit r;
    for (int i = 0; i < count; i++) begin
      case (style)
        RUN_FROM_CORNER: r = (i == 0);
        RUN_SPARSE:      r = ($urandom_range(99) < 3);
        default:         r = $urandom_range(1);
      endcase
      push_word(r);
    end
  endtask

  task automatic wait_results_done();
    while (pending_restart.size() != 0 || in_valid || pixel_expect.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_idle <= 0;  recv_idle <= 0;  end
      1: begin send_idle <= 69; recv_idle <= 0;  end
      2: begin send_idle <= 0;  recv_idle <= 69; end
      default: begin send_idle <= 14; recv_idle <= 14; end
    endcase
  endtask

  function automatic int pick_base();
    if ($urandom_range(3) == 0)
      return $urandom_range(1) ? CMIN : CMAX - 8;
    return int'($urandom_range(CMAX - 8 - CMIN)) + CMIN;
  endfunction

  initial begin
    int phase;
    int shape;
    int n;
    int bx0;
    int by0;
    int dx;
    int dy;
    int k;
    run_style_t style;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset box is the single pixel at the origin
    set_idle(0);
    push_word(1'b0);
    push_word(1'b0);
    push_word(1'b1);
    wait_results_done();

    load_triangle(CMIN, CMIN, CMIN + 2, CMIN, CMIN, CMIN + 2);
    settle_cfg();
    push_word(1'b1);
    repeat (9) push_word(1'b0);
    wait_results_done();

    load_triangle(CMAX, CMAX, CMAX - 2, CMAX, CMAX, CMAX - 3);
    settle_cfg();
    push_word(1'b0);
    push_word(1'b0);
    push_word(1'b1);
    repeat (5) push_word(1'b0);
    wait_results_done();

    // collinear triangle, then writes to unused indexes leave the scan alone
    load_triangle(-3, -3, 0, 0, 3, 3);
    settle_cfg();
    push_word(1'b1);
    repeat (3) push_word(1'b0);
    wait_results_done();
    write_reg(REG_NONE_LO, $urandom);
    write_reg(REG_NONE_HI, $urandom);
    settle_cfg();
    push_word(1'b0);
    wait_results_done();

    phase = 0;
    while (queued < ITEM_TARGET) begin
      set_idle(phase % 4);
      shape = $urandom_range(9);
      bx0 = pick_base();
      by0 = pick_base();
      case (shape)
        0: load_triangle(bx0, by0, bx0, by0, bx0, by0);
        1: begin
          dx = $urandom_range(4);
          dy = $urandom_range(4);
          if ($urandom_range(1))
            load_triangle(bx0, by0, bx0 + dx, by0 + dy, bx0 + 2 * dx, by0 + 2 * dy);
          else
            load_triangle(bx0, by0 + 2 * dy, bx0 + dx, by0 + dy, bx0 + 2 * dx, by0);
        end
        2: load_triangle(int'($urandom_range(CMAX - CMIN)) + CMIN,
                         int'($urandom_range(CMAX - CMIN)) + CMIN,
                         int'($urandom_range(CMAX - CMIN)) + CMIN,
                         int'($urandom_range(CMAX - CMIN)) + CMIN,
                         int'($urandom_range(CMAX - CMIN)) + CMIN,
                         int'($urandom_range(CMAX - CMIN)) + CMIN);
        default: load_triangle(bx0 + $urandom_range(8), by0 + $urandom_range(8),
                               bx0 + $urandom_range(8), by0 + $urandom_range(8),
                               bx0 + $urandom_range(8), by0 + $urandom_range(8));
      endcase
      if ($urandom_range(5) == 0)
        write_reg($urandom_range(1) ? REG_NONE_LO : REG_NONE_HI, $urandom);
      if ($urandom_range(5) == 0) begin
        k = $urandom_range(NUM_VERTEX_REGS - 1);
        write_reg(IW'(k), ((k % 2) ? by0 : bx0) + $urandom_range(8));
      end
      settle_cfg();

      n = $urandom_range(30, 90);
      k = $urandom_range(9);
      style = (k < 6) ? RUN_FROM_CORNER : (k < 9) ? RUN_SPARSE : RUN_NOISY;
      if (phase % 5 == 2) begin
        queue_words(n / 2, style);
        wait_results_done();
        queue_words(n - n / 2, RUN_SPARSE);
      end else begin
        queue_words(n, style);
      end
      if (phase == 4 || phase == 36)
        hold_req <= hold_req + 1;
      wait_results_done();
      phase++;
    end

    repeat (8) @(posedge clk);
    $display("Scanned %0d pixel words over %0d triangle setups", n_words, phase + 4);
    $display("  (points, lines, edge and full-range boxes).");
    $display("Hit %0d box wraps and %0d covered pixels", n_last, n_inside);
    $display("  across four idle mixes and long output hold-offs.");
    if (failures == 0 && pixel_expect.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### triangle_bbox_edge_rasterizer.f
rtl/core/tbr_pkg.sv
rtl/core/tbr_front.sv
rtl/core/tbr_fifo.sv
rtl/core/tbr_back.sv
rtl/core/triangle_bbox_edge_rasterizer.sv
rtl/core/tbr_checker.sv
bench/tb_triangle_bbox_edge_rasterizer.sv
